// ===== design/multi_timer_table_with_rate_counter_macros.svh =====
// ----------------------------------------------------------------------------
// timer table assertion macros
// small wrappers so that assertions vanish in synthesis
// ----------------------------------------------------------------------------
`ifndef MULTI_TIMER_TABLE_WITH_RATE_COUNTER_MACROS_SVH
`define MULTI_TIMER_TABLE_WITH_RATE_COUNTER_MACROS_SVH
`ifndef SYNTHESIS
`define MTT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("mtt check");
`define MTT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mtt check");
`else
`define MTT_ASSERT(lbl, clk, rst_n, prop)
`define MTT_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== design/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// timer table package
// field widths, result kinds and operation codes
// ----------------------------------------------------------------------------
package mtt_pkg;
  localparam int unsigned MaxTimersDef = 32;
  localparam int unsigned IdBitsDef    = 16;
  localparam int unsigned TimeW        = 24;
  localparam int unsigned FrameW       = 25;
  localparam int unsigned CntW         = 16;

  localparam logic [FrameW-1:0] OneSec = FrameW'(65536);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_FIRED    = 3'd0,
    KIND_TICK     = 3'd1,
    KIND_ADD_OK   = 3'd2,
    KIND_ADD_FULL = 3'd3,
    KIND_REMOVE   = 3'd4
  } kind_e;
endpackage

// ===== design/multi_timer_table_with_rate_counter.sv =====
// An add gives its result from the output register; a remove or a tick walks all
// slots, one slot a cycle, and then gives its last result. A tick's walk goes through the
// shared sum/compare unit and holds while a fired result is stalled; a remove's walk
// compares ids only. The next item is taken in the cycle after the last result
// transfer. One item at a time.
// Reset clears slot flags, id and rate counters at once; slot payload undefined.
// ----------------------------------------------------------------------------
// timer table with frame-rate counter
// ordered timer table advanced one slot a cycle, unless a fired result is stalled, by a shared adder/comparator
// ----------------------------------------------------------------------------
`include "multi_timer_table_with_rate_counter_macros.svh"
module multi_timer_table_with_rate_counter #(
  parameter int unsigned MAX_TIMERS = mtt_pkg::MaxTimersDef,
  parameter int unsigned ID_BITS    = mtt_pkg::IdBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [23:0] delta_time_i,
  input  logic [23:0] interval_i,
  input  logic        repeat_req_i,
  input  logic [15:0] target_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [15:0] timer_id_o,
  output logic [15:0] frame_rate_o,
  output logic        last_o
);
  import mtt_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_TIMERS + 1);
  localparam int unsigned SlW  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_REM  = 3'd2;
  localparam logic [2:0] S_END  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  // slot storage, compacted in place during the walk
  logic [MAX_TIMERS-1:0] used_q, pend_q, mark_q;
  logic                  rep_q    [MAX_TIMERS];
  logic [ID_BITS-1:0]    ident_q  [MAX_TIMERS];
  logic [TimeW-1:0]      period_q [MAX_TIMERS];
  logic [TimeW-1:0]      elap_q   [MAX_TIMERS];

  logic [ID_BITS-1:0] next_id_q;
  logic [CntW-1:0]    frames_q, rate_q;
  logic [FrameW-1:0]  felap_q;

  logic [IdxW-1:0]    rd_q, wr_q, cnt_q;
  logic [TimeW-1:0]   dt_q;
  logic [15:0]        tgt_q;

  // output register
  logic        ovalid_q, olast_q;
  logic [2:0]  okind_q;
  logic [15:0] oid_q, orate_q;

  logic in_acc, out_free;
  assign out_free   = !ovalid_q || !out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || ovalid_q;

  // shared sum/compare unit on the slot under the read pointer
  logic [SlW-1:0]   rd_ix, wr_ix;
  logic [TimeW:0]   sum_w;
  logic [TimeW-1:0] sum_sat, sum_new;
  logic             rd_active, fire, drop;
  assign rd_ix     = rd_q[SlW-1:0];
  assign wr_ix     = wr_q[SlW-1:0];
  assign rd_active = used_q[rd_ix] && !pend_q[rd_ix];
  assign sum_w     = {1'b0, elap_q[rd_ix]} + {1'b0, dt_q};
  assign sum_sat   = sum_w[TimeW] ? {TimeW{1'b1}} : sum_w[TimeW-1:0];
  assign fire      = rd_active && (sum_sat >= period_q[rd_ix]);
  assign sum_new   = (fire && rep_q[rd_ix]) ? sum_sat - period_q[rd_ix] :
                     (rd_active ? sum_sat : elap_q[rd_ix]);
  assign drop      = rd_active && ((fire && !rep_q[rd_ix]) || mark_q[rd_ix]);

  logic walk_step;
  assign walk_step = (state_q == S_WALK) && (!fire || out_free);

  // rate counter next values
  logic [FrameW:0]   fsum;
  logic [FrameW-1:0] fsat;
  logic [CntW-1:0]   finc;
  assign fsum = {1'b0, felap_q} + {1'b0, FrameW'(delta_time_i)};
  assign fsat = fsum[FrameW] ? {FrameW{1'b1}} : fsum[FrameW-1:0];
  assign finc = (frames_q == {CntW{1'b1}}) ? frames_q : frames_q + CntW'(1);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        unique case (op_e'(operation_i))
          OP_TICK:   state_d = S_WALK;
          OP_REMOVE: state_d = S_REM;
          OP_ADD:    state_d = S_IDLE;
          default:   state_d = S_IDLE;
        endcase
      end
      S_WALK: if (walk_step && rd_q == IdxW'(MAX_TIMERS - 1)) state_d = S_END;
      S_REM:  if (rd_q == IdxW'(MAX_TIMERS - 1)) state_d = S_OUT;
      S_END:  if (out_free) state_d = S_IDLE;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      pend_q    <= '0;
      mark_q    <= '0;
      next_id_q <= '0;
      frames_q  <= '0;
      rate_q    <= '0;
      felap_q   <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      cnt_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_acc) begin
          rd_q <= '0;
          wr_q <= '0;
          unique case (op_e'(operation_i))
            OP_TICK: begin
              if (fsat >= OneSec) begin
                rate_q   <= finc;
                felap_q  <= fsat - OneSec;
                frames_q <= '0;
              end else begin
                felap_q  <= fsat;
                frames_q <= finc;
              end
            end
            OP_ADD: begin
              ovalid_q <= 1'b1;
              if (cnt_q < IdxW'(MAX_TIMERS)) begin
                used_q[cnt_q[SlW-1:0]] <= 1'b1;
                pend_q[cnt_q[SlW-1:0]] <= 1'b1;
                mark_q[cnt_q[SlW-1:0]] <= 1'b0;
                cnt_q     <= cnt_q + IdxW'(1);
                next_id_q <= next_id_q + ID_BITS'(1);
              end
            end
            OP_REMOVE: ;
            default: ;
          endcase
        end
        S_WALK: if (walk_step) begin
          rd_q <= rd_q + IdxW'(1);
          if (fire) ovalid_q <= 1'b1;
          if (used_q[rd_ix] && !drop) begin
            used_q[wr_ix] <= 1'b1;
            pend_q[wr_ix] <= 1'b0;
            mark_q[wr_ix] <= 1'b0;
            wr_q <= wr_q + IdxW'(1);
          end
          if (wr_ix != rd_ix || !used_q[rd_ix] || drop) begin
            used_q[rd_ix] <= (used_q[rd_ix] && !drop) && (wr_ix == rd_ix);
            pend_q[rd_ix] <= 1'b0;
            mark_q[rd_ix] <= 1'b0;
          end
        end
        S_REM: begin
          rd_q <= rd_q + IdxW'(1);
          if (rd_active && 32'(ident_q[rd_ix]) == 32'(tgt_q)) mark_q[rd_ix] <= 1'b1;
        end
        S_END: begin
          cnt_q <= wr_q;
          if (out_free) ovalid_q <= 1'b1;
        end
        S_OUT: if (out_free) ovalid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // slot payload and output payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) begin
      dt_q  <= delta_time_i;
      tgt_q <= target_id_i;
      olast_q <= 1'b1;
      orate_q <= '0;
      oid_q   <= '0;
      if (op_e'(operation_i) == OP_ADD) begin
        if (cnt_q < IdxW'(MAX_TIMERS)) begin
          okind_q <= KIND_ADD_OK;
          oid_q   <= 16'(next_id_q);
          rep_q[cnt_q[SlW-1:0]]    <= repeat_req_i;
          ident_q[cnt_q[SlW-1:0]]  <= next_id_q;
          period_q[cnt_q[SlW-1:0]] <= interval_i;
          elap_q[cnt_q[SlW-1:0]]   <= '0;
        end else begin
          okind_q <= KIND_ADD_FULL;
        end
      end else begin
        okind_q <= KIND_REMOVE;
      end
    end
    if (walk_step) begin
      if (fire) begin
        okind_q <= KIND_FIRED;
        oid_q   <= 16'(ident_q[rd_ix]);
        orate_q <= '0;
        olast_q <= 1'b0;
      end
      if (used_q[rd_ix] && !drop) begin
        rep_q[wr_ix]    <= rep_q[rd_ix];
        ident_q[wr_ix]  <= ident_q[rd_ix];
        period_q[wr_ix] <= period_q[rd_ix];
        elap_q[wr_ix]   <= sum_new;
      end
    end
    // tick done waits until the last fired result has left
    if (state_q == S_END && out_free) begin
      okind_q <= KIND_TICK;
      oid_q   <= '0;
      orate_q <= rate_q;
      olast_q <= 1'b1;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign kind_o       = okind_q;
  assign timer_id_o   = oid_q;
  assign frame_rate_o = orate_q;
  assign last_o       = olast_q;

  // checks
  `MTT_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= IdxW'(MAX_TIMERS))
  `MTT_ASSERT(a_wr_behind, clk_i, rst_ni, wr_q <= rd_q)
  `MTT_ASSERT_NEXT(a_held, clk_i, rst_ni, ovalid_q && out_stall_i, ovalid_q && $stable(okind_q))
endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// timer table testbench
// drives add, remove, tick and no-op transfers from a queue, predicts the results
// with a behavioural copy of the table and checks every result transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
  import mtt_pkg::*;

  localparam int NSlots    = int'(MaxTimersDef);
  localparam int LimitCyc  = 400000;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] dt;
    logic [23:0] per;
    logic        rep;
    logic [15:0] tgt;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] id;
    logic [15:0] rate;
    logic        last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = '0;
  logic [23:0] delta_time_i = '0;
  logic [23:0] interval_i = '0;
  logic repeat_req_i = 1'b0;
  logic [15:0] target_id_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] kind_o;
  logic [15:0] timer_id_o;
  logic [15:0] frame_rate_o;
  logic last_o;

  multi_timer_table_with_rate_counter uut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   errors = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;     // no idling in the closing part
  bit   hold_off = 1'b0;  // sender waits until the table has answered

  // timer table copy
  bit          t_used[NSlots], t_pend[NSlots], t_mark[NSlots], t_rep[NSlots];
  logic [15:0] t_id[NSlots];
  logic [23:0] t_per[NSlots], t_sum[NSlots];
  logic [15:0] id_next = '0, frames = '0, rate = '0;
  logic [24:0] frame_sum = '0;
  int          live_ids[$];

  // queue append helpers
  task automatic queue_cmd(input cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic expect_res(input res_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  function automatic res_t mk(logic [2:0] k, logic [15:0] id, logic [15:0] r, logic l);
    res_t x;
    x.kind = k; x.id = id; x.rate = r; x.last = l;
    return x;
  endfunction

  task automatic predict_table(input cmd_t c);
    int n, w;
    bit drop[NSlots];
    logic [25:0] s;
    n = 0;
    w = 0;
    case (op_e'(c.op))
      OP_TICK: begin
        if (frames != 16'hffff) frames++;
        s = frame_sum + c.dt;
        frame_sum = (s > 26'h1ffffff) ? 25'h1ffffff : s[24:0];
        if (frame_sum >= OneSec) begin
          rate = frames;
          frame_sum -= OneSec;
          frames = '0;
        end
        for (int i = 0; i < NSlots; i++) begin
          drop[i] = 1'b0;
          if (t_used[i] && !t_pend[i]) begin
            s = t_sum[i] + c.dt;
            t_sum[i] = (s > 26'hffffff) ? 24'hffffff : s[23:0];
            if (t_sum[i] >= t_per[i]) begin
              expect_res(mk(KIND_FIRED, t_id[i], '0, 1'b0));
              if (t_rep[i]) t_sum[i] -= t_per[i];
              else drop[i] = 1'b1;
            end
            if (t_mark[i]) drop[i] = 1'b1;
          end
        end
        for (int i = 0; i < NSlots; i++) begin
          if (t_used[i] && !drop[i]) begin
            t_used[w] = 1'b1; t_pend[w] = 1'b0; t_mark[w] = 1'b0;
            t_rep[w] = t_rep[i]; t_id[w] = t_id[i];
            t_per[w] = t_per[i]; t_sum[w] = t_sum[i];
            w++;
          end
        end
        for (int i = w; i < NSlots; i++) begin
          t_used[i] = 1'b0; t_pend[i] = 1'b0; t_mark[i] = 1'b0;
        end
        expect_res(mk(KIND_TICK, '0, rate, 1'b1));
      end
      OP_ADD: begin
        for (int i = 0; i < NSlots; i++) if (t_used[i]) n++;
        if (n >= NSlots) begin
          expect_res(mk(KIND_ADD_FULL, '0, '0, 1'b1));
        end else begin
          t_used[n] = 1'b1; t_pend[n] = 1'b1; t_mark[n] = 1'b0;
          t_rep[n] = c.rep; t_id[n] = id_next; t_per[n] = c.per; t_sum[n] = '0;
          expect_res(mk(KIND_ADD_OK, id_next, '0, 1'b1));
          live_ids.insert(live_ids.size(), int'(id_next));
          id_next++;
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < NSlots; i++)
          if (t_used[i] && !t_pend[i] && t_id[i] == c.tgt) t_mark[i] = 1'b1;
        expect_res(mk(KIND_REMOVE, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    cmd_t c;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_table({operation_i, delta_time_i,
        interval_i, repeat_req_i, target_id_i});
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 13) - 1;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     !(hold_off && expected_results.size() > 0) &&
                     !(hold_off && in_valid_i && !in_stall_o)) begin
          c = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= c.op; delta_time_i <= c.dt; interval_i <= c.per;
          repeat_req_i <= c.rep; target_id_i <= c.tgt;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor with receiver stalls
  int out_gap = 0;
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d id %0d", $time, kind_o, timer_id_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (kind_o !== e.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, e.kind, kind_o); errors++;
          end
          if (timer_id_o !== e.id) begin
            $display("%0t: id exp %0d got %0d", $time, e.id, timer_id_o); errors++;
          end
          if (frame_rate_o !== e.rate) begin
            $display("%0t: rate exp %0d got %0d", $time, e.rate, frame_rate_o); errors++;
          end
          if (last_o !== e.last) begin
            $display("%0t: last exp %0d got %0d", $time, e.last, last_o); errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(1, 13) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
      if (cycles > LimitCyc) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic cmd_t op_cmd(logic [1:0] op, logic [23:0] dt, logic [23:0] per,
                                  logic rep, logic [15:0] tgt);
    cmd_t c;
    c.op = op; c.dt = dt; c.per = per; c.rep = rep; c.tgt = tgt;
    return c;
  endfunction

  function automatic logic [23:0] rnd_time();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hffffff;
      2: return 24'($urandom_range(0, 65536));
      default: return 24'($urandom_range(1000, 40000));
    endcase
  endfunction

  // sampled away from the rising edge so driver updates have settled
  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    cmd_t c;
    int k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every operation, special cases
    queue_cmd(op_cmd(OP_TICK, 24'd0, '0, 1'b0, '0));
    queue_cmd(op_cmd(OP_ADD, '0, 24'd0, 1'b1, '0));        // zero period
    queue_cmd(op_cmd(OP_ADD, '0, 24'hffffff, 1'b0, '0));
    queue_cmd(op_cmd(OP_ADD, '0, 24'd30000, 1'b0, '0));
    queue_cmd(op_cmd(OP_REMOVE, '0, '0, 1'b0, 16'd1));     // still pending
    queue_cmd(op_cmd(OP_NONE, 24'hffffff, 24'hffffff, 1'b1, 16'hffff));
    queue_cmd(op_cmd(OP_TICK, 24'hffffff, '0, 1'b0, '0));  // saturating sums
    queue_cmd(op_cmd(OP_REMOVE, '0, '0, 1'b0, 16'hffff));  // unknown id
    queue_cmd(op_cmd(OP_REMOVE, '0, '0, 1'b0, 16'd0));     // marked, fires
    queue_cmd(op_cmd(OP_TICK, 24'd40000, '0, 1'b0, '0));
    queue_cmd(op_cmd(OP_TICK, 24'hffffff, '0, 1'b0, '0));
    wait_drained();

    // fill the table then overflow
    for (int i = 0; i < 34; i++)
      queue_cmd(op_cmd(OP_ADD, '0, 24'($urandom_range(1, 200000)),
                       1'($urandom_range(0, 1)), '0));
    queue_cmd(op_cmd(OP_TICK, 24'd70000, '0, 1'b0, '0));
    queue_cmd(op_cmd(OP_TICK, 24'd70000, '0, 1'b0, '0));
    wait_drained();

    // sender waits for every result before each item
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++)
      queue_cmd(op_cmd(2'($urandom_range(0, 1)), rnd_time(), rnd_time(),
                       1'($urandom_range(0, 1)), '0));
    wait_drained();
    hold_off = 1'b0;

    // random: mostly add/tick/remove of live ids, some noise
    for (int i = 0; i < 70; i++) begin
      if (i == 55) begin
        wait_drained();
        quiet = 1'b1;
      end
      k = $urandom_range(0, 9);
      c.op = (k < 4) ? OP_TICK : (k < 7) ? OP_ADD : (k < 9) ? OP_REMOVE : OP_NONE;
      c.dt = rnd_time();
      c.per = rnd_time();
      c.rep = 1'($urandom_range(0, 1));
      c.tgt = 16'($urandom);
      if (c.op == OP_REMOVE && live_ids.size() > 0 && $urandom_range(0, 3) != 0)
        c.tgt = 16'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
      queue_cmd(c);
    end
    wait_drained();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
